// ===== sv/vtbb_pkg.sv =====
// ----------------------------------------------------------------------------
// vtbb_pkg
// Shared types, constants and helpers for the vertex transform with
// bounding box core: widths, register indexes, reset values, corner order.
// ----------------------------------------------------------------------------
package vtbb_pkg;

  // coordinate and coefficient formats
  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 8;
  localparam int COEF_W    = 16;
  localparam int NUM_SLOTS = 4;
  localparam int ROW_W     = COEF_W * NUM_SLOTS;
  localparam int PROD_W    = COORD_W + COEF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int SHR_W     = SUM_W - FRAC_BITS;
  localparam int NUM_AXES  = 3;

  // coefficient slots inside a row
  localparam int SLOT_T = 3;

  // box corner sequence
  localparam int NUM_CORNERS = 24;
  localparam int CNT_W       = $clog2(NUM_CORNERS);

  // configuration register map
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BOX_ENABLE = CFG_IDX_W'(3);

  // identity rows after reset
  localparam logic [ROW_W-1:0] ROW_X_RESET = ROW_W'(64'h0000_0000_0000_0100);
  localparam logic [ROW_W-1:0] ROW_Y_RESET = ROW_W'(64'h0000_0000_0100_0000);
  localparam logic [ROW_W-1:0] ROW_Z_RESET = ROW_W'(64'h0000_0100_0000_0000);

  // result kinds
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_CORNER = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  // Corner selector: bit 2 picks max x, bit 1 max y, bit 0 max z.
  function automatic logic [2:0] corner_sel(input logic [CNT_W-1:0] idx);
    logic [2:0] s;
    case (idx)
      CNT_W'(0):  s = 3'd3;
      CNT_W'(1):  s = 3'd1;
      CNT_W'(2):  s = 3'd5;
      CNT_W'(3):  s = 3'd7;
      CNT_W'(4):  s = 3'd7;
      CNT_W'(5):  s = 3'd5;
      CNT_W'(6):  s = 3'd4;
      CNT_W'(7):  s = 3'd6;
      CNT_W'(8):  s = 3'd3;
      CNT_W'(9):  s = 3'd2;
      CNT_W'(10): s = 3'd0;
      CNT_W'(11): s = 3'd1;
      CNT_W'(12): s = 3'd3;
      CNT_W'(13): s = 3'd7;
      CNT_W'(14): s = 3'd6;
      CNT_W'(15): s = 3'd2;
      CNT_W'(16): s = 3'd2;
      CNT_W'(17): s = 3'd6;
      CNT_W'(18): s = 3'd4;
      CNT_W'(19): s = 3'd0;
      CNT_W'(20): s = 3'd1;
      CNT_W'(21): s = 3'd0;
      CNT_W'(22): s = 3'd4;
      CNT_W'(23): s = 3'd5;
      default:    s = 3'd0;
    endcase
    return s;
  endfunction

  // Sum three products and the translation, floor to FRAC_BITS, saturate.
  function automatic coord_t row_result(input prod_t p0, input prod_t p1,
                                        input prod_t p2, input coef_t t);
    sum_t                    acc;
    logic signed [SHR_W-1:0] shr;
    coord_t                  r;
    acc = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2)
        + (SUM_W'(t) <<< FRAC_BITS);
    shr = acc[SUM_W-1:FRAC_BITS];
    if (shr[SHR_W-1:COORD_W-1] == '0 || shr[SHR_W-1:COORD_W-1] == '1) begin
      r = shr[COORD_W-1:0];
    end else if (shr[SHR_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== sv/vertex_transform_with_bounding_box_core.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_with_bounding_box_core
// Affine transform of Q8.8 vertices by three matrix rows, with a running
// axis-aligned box emitted as 24 corner words after a last-marked vertex.
// ----------------------------------------------------------------------------
// An accepted input word moves through the input, product and sum registers
// to the output register. Throughput: one vertex per cycle while m_axis takes
// words. A last vertex with the box enabled adds 24 corner words, one per cycle
// while the output register is free; the input holds off once the pipeline fills.
// Reset (rst, synchronous): pipeline empty, identity rows, box enabled,
// box tracking restarted.
module vertex_transform_with_bounding_box_core
  import vtbb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data,
  // input vertices
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,  // in_x[15:0], in_y[31:16], in_z[47:32]
  input  logic                 s_axis_tlast,  // in_last
  // results
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,  // out_x[15:0], out_y[31:16], out_z[47:32]
  output logic                 m_axis_tuser,  // out_kind
  output logic                 m_axis_tlast   // out_last
);

  // configuration registers
  logic [ROW_W-1:0] row_coeffs [NUM_AXES];
  logic             box_enable;

  // input register
  logic   a_valid;
  coord_t a_v [NUM_AXES];
  logic   a_last;

  // product register
  logic   b_valid;
  prod_t  b_p [NUM_AXES][NUM_AXES];
  coef_t  b_t [NUM_AXES];
  logic   b_last;

  // transformed vertex register
  logic   c_valid;
  coord_t c_v [NUM_AXES];
  logic   c_last;

  // box tracking
  coord_t box_min [NUM_AXES];
  coord_t box_max [NUM_AXES];
  logic   seen_first;

  // corner sequencer
  logic             corner_active;
  logic [CNT_W-1:0] corner_cnt;
  logic [2:0]       sel;

  // flow control
  logic out_free, load_corner, load_vertex, c_move, b_move, a_move;

  assign cfg_ready   = 1'b1;
  assign out_free    = !m_axis_tvalid || m_axis_tready;
  assign load_corner = corner_active && out_free;
  assign load_vertex = !corner_active && c_valid && out_free;
  assign c_move      = !c_valid || load_vertex;
  assign b_move      = !b_valid || c_move;
  assign a_move      = !a_valid || b_move;
  assign s_axis_tready = a_move;
  assign sel         = corner_sel(corner_cnt);

  // write configuration registers, drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_coeffs[0] <= ROW_X_RESET;
      row_coeffs[1] <= ROW_Y_RESET;
      row_coeffs[2] <= ROW_Z_RESET;
      box_enable    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_X:      row_coeffs[0] <= cfg_data;
        REG_ROW_Y:      row_coeffs[1] <= cfg_data;
        REG_ROW_Z:      row_coeffs[2] <= cfg_data;
        REG_BOX_ENABLE: box_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_move) a_valid <= s_axis_tvalid;
      if (b_move) b_valid <= a_valid;
      if (c_move) c_valid <= b_valid;
    end
  end

  // capture the input word
  always_ff @(posedge clk) begin
    if (a_move) begin
      a_v[0] <= s_axis_tdata[15:0];
      a_v[1] <= s_axis_tdata[31:16];
      a_v[2] <= s_axis_tdata[47:32];
      a_last <= s_axis_tlast;
    end
  end

  // multiply each coordinate by its coefficient, row by row
  always_ff @(posedge clk) begin
    if (b_move) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int s = 0; s < NUM_AXES; s++) begin
          b_p[r][s] <= PROD_W'(coef_t'(row_coeffs[r][COEF_W*s +: COEF_W])) * PROD_W'(a_v[s]);
        end
        b_t[r] <= row_coeffs[r][COEF_W*SLOT_T +: COEF_W];
      end
      b_last <= a_last;
    end
  end

  // add, rescale and saturate
  always_ff @(posedge clk) begin
    if (c_move) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        c_v[r] <= row_result(b_p[r][0], b_p[r][1], b_p[r][2], b_t[r]);
      end
      c_last <= b_last;
    end
  end

  // track the box as vertices leave; restart after a last vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first <= 1'b0;
      for (int r = 0; r < NUM_AXES; r++) begin
        box_min[r] <= '0;
        box_max[r] <= '0;
      end
    end else if (load_vertex) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        if (!seen_first || c_v[r] < box_min[r]) box_min[r] <= c_v[r];
        if (!seen_first || c_v[r] > box_max[r]) box_max[r] <= c_v[r];
      end
      seen_first <= !c_last;
    end
  end

  // step through the corner sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_active <= 1'b0;
      corner_cnt    <= '0;
    end else if (load_vertex && c_last && box_enable) begin
      corner_active <= 1'b1;
      corner_cnt    <= '0;
    end else if (load_corner) begin
      if (corner_cnt == CNT_W'(NUM_CORNERS - 1)) begin
        corner_active <= 1'b0;
        corner_cnt    <= '0;
      end else begin
        corner_cnt <= corner_cnt + 1'b1;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_corner || load_vertex) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // output register payload: a corner or the transformed vertex
  always_ff @(posedge clk) begin
    if (load_corner) begin
      m_axis_tdata <= {sel[0] ? box_max[2] : box_min[2],
                       sel[1] ? box_max[1] : box_min[1],
                       sel[2] ? box_max[0] : box_min[0]};
      m_axis_tuser <= KIND_CORNER;
      m_axis_tlast <= (corner_cnt == CNT_W'(NUM_CORNERS - 1));
    end else if (load_vertex) begin
      m_axis_tdata <= {c_v[2], c_v[1], c_v[0]};
      m_axis_tuser <= KIND_VERTEX;
      m_axis_tlast <= c_last && !box_enable;
    end
  end

endmodule

// ===== bench/vertex_transform_with_bounding_box_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_transform_with_bounding_box_core_test
// Self-checking bench for the vertex transform core. Vertices stream in on
// s_axis. A scoreboard predicts each transformed vertex and, with the box on, the
// 24 box corner words that follow a last-marked vertex, and matches them in order
// against m_axis. Runs directed corner cases, then random meshes under several
// sender idle and receiver stall mixes, with register rewrites between meshes.
// ----------------------------------------------------------------------------
module vertex_transform_with_bounding_box_core_test;
  import vtbb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(4);
  localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   kind;
    logic   last;
  } result_word_t;

  // Predicts result words per accepted vertex and matches them against m_axis.
  class vertex_scoreboard;
    logic [ROW_W-1:0] rows[NUM_AXES];
    logic             box_on;
    coord_t           lo[NUM_AXES];
    coord_t           hi[NUM_AXES];
    bit               mesh_open;
    result_word_t     expected_q[$];
    int unsigned      failures;
    // bit 2 picks max x, bit 1 max y, bit 0 max z
    bit [2:0]         corner_pick[NUM_CORNERS] = '{
      3'd3, 3'd1, 3'd5, 3'd7, 3'd7, 3'd5, 3'd4, 3'd6, 3'd3, 3'd2, 3'd0, 3'd1,
      3'd3, 3'd7, 3'd6, 3'd2, 3'd2, 3'd6, 3'd4, 3'd0, 3'd1, 3'd0, 3'd4, 3'd5};

    function new();
      rows[0]   = ROW_X_RESET;
      rows[1]   = ROW_Y_RESET;
      rows[2]   = ROW_Z_RESET;
      box_on    = 1'b1;
      mesh_open = 1'b0;
      failures  = 0;
      for (int a = 0; a < NUM_AXES; a++) begin
        lo[a] = '0;
        hi[a] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] val);
      case (idx)
        REG_ROW_X:      rows[0] = val;
        REG_ROW_Y:      rows[1] = val;
        REG_ROW_Z:      rows[2] = val;
        REG_BOX_ENABLE: box_on  = val[0];
        default: ;
      endcase
    endfunction

    // Dot product with w = 1, floor to 8 fraction bits, saturate.
    function coord_t transform_axis(logic [ROW_W-1:0] row, coord_t x, coord_t y,
                                    coord_t z);
      longint acc;
      longint term[NUM_SLOTS];
      coef_t  cv;
      term[0]      = x;
      term[1]      = y;
      term[2]      = z;
      term[SLOT_T] = longint'(1) <<< FRAC_BITS;
      acc = 0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        cv  = row[COEF_W*s +: COEF_W];
        acc = acc + longint'(cv) * term[s];
      end
      acc = acc >>> FRAC_BITS;
      if (acc > COORD_MAX) return coord_t'(COORD_MAX);
      if (acc < COORD_MIN) return coord_t'(COORD_MIN);
      return coord_t'(acc);
    endfunction

    function void note_vertex(coord_t x, coord_t y, coord_t z, logic last);
      coord_t       t[NUM_AXES];
      result_word_t w;
      bit [2:0]     pick;
      t[0] = transform_axis(rows[0], x, y, z);
      t[1] = transform_axis(rows[1], x, y, z);
      t[2] = transform_axis(rows[2], x, y, z);
      // load the box on the first vertex of a mesh, widen it afterwards
      for (int a = 0; a < NUM_AXES; a++) begin
        if (!mesh_open) begin
          lo[a] = t[a];
          hi[a] = t[a];
        end else begin
          if (t[a] < lo[a]) lo[a] = t[a];
          if (t[a] > hi[a]) hi[a] = t[a];
        end
      end
      mesh_open = 1'b1;
      w.x    = t[0];
      w.y    = t[1];
      w.z    = t[2];
      w.kind = KIND_VERTEX;
      w.last = last && !box_on;
      expected_q.push_back(w);
      if (last) begin
        if (box_on) begin
          for (int c = 0; c < NUM_CORNERS; c++) begin
            pick   = corner_pick[c];
            w.x    = pick[2] ? hi[0] : lo[0];
            w.y    = pick[1] ? hi[1] : lo[1];
            w.z    = pick[0] ? hi[2] : lo[2];
            w.kind = KIND_CORNER;
            w.last = (c == NUM_CORNERS - 1);
            expected_q.push_back(w);
          end
        end
        mesh_open = 1'b0;
      end
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        failures++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_word(coord_t x, coord_t y, coord_t z, logic kind, logic last);
      result_word_t w;
      if (expected_q.size() == 0) begin
        failures++;
        $display("%0t: unexpected word expected none, got x=%0d y=%0d z=%0d kind=%0d last=%0d",
                 $time, x, y, z, kind, last);
        return;
      end
      w = expected_q.pop_front();
      compare_field("x", w.x, x);
      compare_field("y", w.y, y);
      compare_field("z", w.z, z);
      compare_field("kind", w.kind, kind);
      compare_field("last", w.last, last);
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [47:0]          s_axis_tdata = '0;   // in_x[15:0], in_y[31:16], in_z[47:32]
  logic                 s_axis_tlast = 1'b0; // in_last
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [47:0]          m_axis_tdata;        // out_x[15:0], out_y[31:16], out_z[47:32]
  logic                 m_axis_tuser;        // out_kind
  logic                 m_axis_tlast;        // out_last

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  vertex_scoreboard sb = new();

  vertex_transform_with_bounding_box_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // stall the result side at random
  initial begin
    forever begin
      @(negedge clk);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check every accepted result word
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                    m_axis_tuser, m_axis_tlast);
  end

  // hard stop for a hung pipeline
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [ROW_W-1:0] pack_row(coef_t cx, coef_t cy, coef_t cz,
                                                 coef_t ct);
    return {ct, cz, cy, cx};
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3:    return coord_t'(int'($urandom_range(1023)) - 512);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Mix small, extreme and fully random coefficients; lean toward a scale of one.
  function automatic logic [ROW_W-1:0] pick_row(int axis);
    logic [ROW_W-1:0] row;
    coef_t            cv;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      case ($urandom_range(7))
        0:       cv = coef_t'($urandom);
        1:       cv = 16'sh7fff;
        2:       cv = 16'sh8000;
        3:       cv = '0;
        default: cv = coef_t'(int'($urandom_range(767)) - 384 + ((s == axis) ? 256 : 0));
      endcase
      row[COEF_W*s +: COEF_W] = cv;
    end
    return row;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_vertex(coord_t x, coord_t y, coord_t z, logic last);
    @(negedge clk);
    // hold off the sender at random
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_vertex(x, y, z, last);
  endtask

  // Drop valid and wait until every expected word has come out.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_mesh(output int unsigned len);
    len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    for (int unsigned i = 0; i < len; i++)
      send_vertex(pick_coord(), pick_coord(), pick_coord(), i == len - 1);
  endtask

  task automatic reconfigure();
    logic [ROW_W-1:0] val;
    drain();
    write_reg(REG_ROW_X, pick_row(0));
    write_reg(REG_ROW_Y, pick_row(1));
    write_reg(REG_ROW_Z, pick_row(2));
    val    = {$urandom, $urandom};
    val[0] = ($urandom_range(4) != 0);
    write_reg(REG_BOX_ENABLE, val);
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(4, 255)), {$urandom, $urandom});
  endtask

  initial begin
    int unsigned phase_send[4];
    int unsigned phase_recv[4];
    int unsigned sent;
    int unsigned mesh_len;

    phase_send = '{0, 59, 0, 26};
    phase_recv = '{0, 0, 59, 26};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity rows: extremes, a mesh with the box, a single-vertex mesh
    send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
    send_vertex(16'sh7fff, 16'sh8000, 16'sh0001, 1'b0);
    send_vertex(16'sh8000, 16'sh7fff, -16'sh0001, 1'b1);
    send_vertex(16'sh0100, 16'sh0200, -16'sh0300, 1'b1);
    drain();

    // saturating rows, a half scale for floor rounding, box off via a masked write
    write_reg(REG_UNMAPPED, '1);
    write_reg(REG_ROW_X, pack_row(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
    write_reg(REG_ROW_Y, pack_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    write_reg(REG_ROW_Z, pack_row(16'sh0080, 16'sh0000, 16'sh0000, 16'sh0000));
    write_reg(REG_BOX_ENABLE, 64'h2);
    send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_vertex(16'sh0001, 16'sh0000, 16'sh0000, 1'b0);
    send_vertex(-16'sh0001, 16'sh0000, 16'sh0000, 1'b0);
    send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
    drain();

    // extreme translations with the box back on
    write_reg(REG_BOX_ENABLE, 64'h1);
    write_reg(REG_ROW_X, pack_row(16'sh0100, 16'sh0000, 16'sh0000, 16'sh8000));
    write_reg(REG_ROW_Y, pack_row(16'sh0000, -16'sh0100, 16'sh0000, 16'sh7fff));
    write_reg(REG_ROW_Z, pack_row(16'sh0200, 16'sh0200, 16'sh0200, 16'sh0000));
    send_vertex(pick_coord(), pick_coord(), pick_coord(), 1'b0);
    send_vertex(pick_coord(), pick_coord(), pick_coord(), 1'b0);
    send_vertex(pick_coord(), pick_coord(), pick_coord(), 1'b1);

    // random meshes under each idle mix; each phase opens with a full drain
    for (int p = 0; p < 4; p++) begin
      reconfigure();
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      sent = 0;
      while (sent < 75) begin
        if ($urandom_range(3) == 0) reconfigure();
        send_mesh(mesh_len);
        sent = sent + mesh_len;
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/vtbb_pkg.sv
sv/vertex_transform_with_bounding_box_core.sv
bench/vertex_transform_with_bounding_box_core_test.sv
